/* sv/stable_priority_queue_top_defines.svh */
// Assertion macros used by the stable priority queue top module.
// Depends on nothing; defines clocked on i_clk with i_rst_n as disable.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(label, cond, msg)
`define SPQ_ASSERT_IMPL(label, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* sv/spq_pkg.sv */
// Package for the stable priority queue: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int FUNC_W      = 2;
    localparam int PRIO_W      = 8;
    localparam int TAG_W       = 8;
    localparam int POS_W       = 5;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_LIST   = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_cell_ctrl;

endpackage

/* sv/spq_if.sv */
// Handshake interfaces for the request and result channels.
// Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_in_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  task_tag;

    modport source (output valid, func, priority_req, task_tag, input ready);
    modport sink   (input valid, func, priority_req, task_tag, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  out_tag;
    logic [PRIO_W-1:0] out_priority;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, out_tag, out_priority, position, status, last,
                    input ready);
    modport sink   (input valid, out_tag, out_priority, position, status, last,
                    output ready);
endinterface

/* sv/stable_priority_queue_top.sv */
// Stable priority queue: an insert or a pop gives one transfer; a list gives one
// transfer per stored entry, head first, or one EMPTY transfer on an empty queue,
// with the queue contents rotated round the cell row and restored at the end. A new
// request is taken only once the previous one has been fully handed to the output
// register, so a list holds the input until its last entry is handed over, stalls
// included. Entries of equal priority leave in arrival order. Depends on spq_pkg,
// spq_if, spq_cell_row and stable_priority_queue_top_defines.svh.
`timescale 1ns / 1ps
`include "stable_priority_queue_top_defines.svh"

module stable_priority_queue_top
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out
);

    t_state             r_state, n_state;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [OCC_W-1:0]   r_pos, n_pos;
    logic               r_out_valid, n_out_valid;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [PRIO_W-1:0]  r_out_prio, n_out_prio;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    t_status            r_out_stat, n_out_stat;
    logic               r_out_last, n_out_last;

    t_cell_ctrl              cell_ctrl;
    t_entry                  head;
    logic [QUEUE_DEPTH-1:0]  valid_vec;
    logic                    out_free;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [OCC_W-1:0]        pos_inc;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign accept   = i_in.valid && i_in.ready;
    assign full     = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign empty    = (r_occ == '0);
    assign pos_inc  = r_pos + 1'b1;

    spq_cell_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cell_ctrl),
        .o_head  (head),
        .o_valid (valid_vec)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.func == FUNC_LIST) && !empty) begin
                    n_state = ST_LIST;
                end
            end
            ST_LIST: begin
                if (out_free && (pos_inc == r_occ)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        cell_ctrl   = '{op: CELL_HOLD, prio: i_in.priority_req, tag: i_in.task_tag};
        n_occ       = r_occ;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_tag   = r_out_tag;
        n_out_prio  = r_out_prio;
        n_out_pos   = r_out_pos;
        n_out_stat  = r_out_stat;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_tag  = '0;
                    n_out_prio = '0;
                    n_out_pos  = '0;
                    n_out_stat = STAT_OK;
                    n_out_last = 1'b1;
                    n_pos      = '0;
                    unique case (i_in.func)
                        FUNC_INSERT: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_out_stat = STAT_FULL;
                            end else begin
                                cell_ctrl.op = CELL_INSERT;
                                n_occ        = r_occ + 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            n_out_valid = 1'b1;
                            if (empty) begin
                                n_out_stat = STAT_EMPTY;
                            end else begin
                                n_out_tag    = head.tag;
                                n_out_prio   = head.prio;
                                cell_ctrl.op = CELL_POP;
                                n_occ        = r_occ - 1'b1;
                            end
                        end
                        FUNC_LIST: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_out_stat  = STAT_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_tag    = head.tag;
                    n_out_prio   = head.prio;
                    n_out_pos    = POS_W'(pos_inc);
                    n_out_stat   = STAT_OK;
                    n_out_last   = (pos_inc == r_occ);
                    n_pos        = pos_inc;
                    cell_ctrl.op = CELL_ROTATE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_out_tag  <= n_out_tag;
        r_out_prio <= n_out_prio;
        r_out_pos  <= n_out_pos;
        r_out_stat <= n_out_stat;
        r_out_last <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_tag      = r_out_tag;
    assign o_out.out_priority = r_out_prio;
    assign o_out.position     = r_out_pos;
    assign o_out.status       = r_out_stat;
    assign o_out.last         = r_out_last;

    `SPQ_ASSERT_ALWAYS(a_occ_bound, r_occ <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
    `SPQ_ASSERT_ALWAYS(a_occ_matches_cells, $countones(valid_vec) == r_occ,
        "occupancy disagrees with cell valid bits")
    `SPQ_ASSERT_ALWAYS(a_cells_packed, ((valid_vec + 1'b1) & valid_vec) == '0,
        "valid cells not packed from the head")
    `SPQ_ASSERT_IMPL(a_list_nonempty, r_state == ST_LIST, !empty && (r_pos < r_occ),
        "listing past the stored entries")
    `SPQ_ASSERT_NEXT(a_list_keeps_occ, r_state == ST_LIST, $stable(r_occ),
        "occupancy changed during a list")

endmodule

/* sv/spq_cell.sv */
// One storage cell of the sorted row: holds an entry, shifts with its neighbours.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  logic       i_left_take,
    input  t_entry     i_right,
    input  t_entry     i_head,
    output t_entry     o_entry,
    output logic       o_take
);

    logic              r_valid;
    logic [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]  r_tag;
    t_entry            n_entry;

    // insert point is the first empty cell or first strictly greater priority
    assign o_take  = !r_valid || (r_prio > i_ctrl.prio);
    assign o_entry = '{valid: r_valid, prio: r_prio, tag: r_tag};

    always_comb begin
        n_entry = o_entry;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_take) begin
                    if (i_left_take) begin
                        n_entry.prio = i_left.prio;
                        n_entry.tag  = i_left.tag;
                    end else begin
                        n_entry.prio = i_ctrl.prio;
                        n_entry.tag  = i_ctrl.tag;
                    end
                    n_entry.valid = r_valid || i_left.valid;
                end
            end
            CELL_POP: begin
                n_entry = i_right;
            end
            CELL_ROTATE: begin
                if (i_right.valid) begin
                    n_entry = i_right;
                end else if (r_valid) begin
                    n_entry = i_head;
                end
            end
            CELL_HOLD: begin
                n_entry = o_entry;
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_prio <= n_entry.prio;
        r_tag  <= n_entry.tag;
    end

endmodule

/* sv/spq_cell_row.sv */
// Row of QUEUE_DEPTH cells kept in ascending priority order, head at cell 0.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

module spq_cell_row
    import spq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    output t_entry                 o_head,
    output logic [QUEUE_DEPTH-1:0] o_valid
);

    t_entry entries [QUEUE_DEPTH];
    logic   takes   [QUEUE_DEPTH];

    assign o_head = entries[0];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_take;

        if (g == 0) begin : g_first
            assign left_entry = '{valid: 1'b1, prio: '0, tag: '0};
            assign left_take  = 1'b0;
        end else begin : g_mid
            assign left_entry = entries[g-1];
            assign left_take  = takes[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign right_entry = '{valid: 1'b0, prio: '0, tag: '0};
        end else begin : g_inner
            assign right_entry = entries[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_left      (left_entry),
            .i_left_take (left_take),
            .i_right     (right_entry),
            .i_head      (entries[0]),
            .o_entry     (entries[g]),
            .o_take      (takes[g])
        );

        assign o_valid[g] = entries[g].valid;
    end

endmodule
